[hw/rtl/vipc_pkg.sv]
// Package for the VXLAN inner packet classifier: parse phase and status codes,
// header constants, configuration and verdict types.
// No dependencies.
package vipc_pkg;

    localparam int PhaseW = 4;
    localparam int OffW   = 6;
    localparam int HlenW  = 6;
    localparam int StatW  = 4;
    localparam int CfgIdxW = 8;

    localparam logic [PhaseW-1:0] PH_OUTER_ETH = 4'd0;
    localparam logic [PhaseW-1:0] PH_OUTER_IP  = 4'd1;
    localparam logic [PhaseW-1:0] PH_OUTER_UDP = 4'd2;
    localparam logic [PhaseW-1:0] PH_VXLAN     = 4'd3;
    localparam logic [PhaseW-1:0] PH_INNER_ETH = 4'd4;
    localparam logic [PhaseW-1:0] PH_INNER_IP  = 4'd5;
    localparam logic [PhaseW-1:0] PH_ICMP      = 4'd6;
    localparam logic [PhaseW-1:0] PH_TCP       = 4'd7;
    localparam logic [PhaseW-1:0] PH_UDP       = 4'd8;
    localparam logic [PhaseW-1:0] PH_DONE      = 4'd9;

    localparam logic [StatW-1:0] ST_ICMP          = 4'd0;
    localparam logic [StatW-1:0] ST_TCP           = 4'd1;
    localparam logic [StatW-1:0] ST_UDP           = 4'd2;
    localparam logic [StatW-1:0] ST_OTHER         = 4'd3;
    localparam logic [StatW-1:0] ST_OUTER_IHL     = 4'd4;
    localparam logic [StatW-1:0] ST_OUTER_NOT_UDP = 4'd5;
    localparam logic [StatW-1:0] ST_NOT_VXLAN     = 4'd6;
    localparam logic [StatW-1:0] ST_INNER_IHL     = 4'd7;
    localparam logic [StatW-1:0] ST_TCP_OFFSET    = 4'd8;
    localparam logic [StatW-1:0] ST_TRUNCATED     = 4'd9;

    localparam logic [CfgIdxW-1:0] CFG_VXLAN_PORT = 8'd0;
    localparam logic [CfgIdxW-1:0] CFG_VLAN_TYPE  = 8'd1;

    localparam logic [15:0] VXLAN_PORT_RST = 16'd4789;
    localparam logic [15:0] VLAN_TYPE_RST  = 16'h8100;

    localparam logic [7:0] PROTO_ICMP = 8'h01;
    localparam logic [7:0] PROTO_TCP  = 8'h06;
    localparam logic [7:0] PROTO_UDP  = 8'h11;

    localparam logic [7:0] ICMP_ECHO_REPLY = 8'd0;
    localparam logic [7:0] ICMP_ECHO       = 8'd8;

    localparam logic [HlenW-1:0] ETH_HLEN      = 6'd14;
    localparam logic [HlenW-1:0] ETH_VLAN_HLEN = 6'd18;
    localparam logic [3:0]       MIN_WORDS     = 4'd5;

    typedef struct packed {
        logic [15:0] vxlan_udp_port;
        logic [15:0] vlan_tag_type;
    } cfg_t;

    typedef struct packed {
        logic [StatW-1:0] status;
        logic [7:0]       inner_protocol;
        logic [31:0]      inner_src_addr;
        logic [31:0]      inner_dst_addr;
        logic [15:0]      src_port;
        logic [15:0]      dst_port;
        logic [7:0]       tcp_flags;
        logic [7:0]       icmp_type;
        logic [15:0]      echo_id;
        logic [15:0]      echo_seq;
    } verdict_t;

    typedef struct packed {
        logic     valid;
        verdict_t verdict;
    } res_push_t;

endpackage

[hw/rtl/vipc_channels.sv]
// Channel interfaces of the classifier: frame bytes in, verdicts out, config writes.
// Depends on vipc_pkg.
interface vipc_frame_if import vipc_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface vipc_verdict_if import vipc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [StatW-1:0] status;
    logic [7:0]       inner_protocol;
    logic [31:0]      inner_src_addr;
    logic [31:0]      inner_dst_addr;
    logic [15:0]      src_port;
    logic [15:0]      dst_port;
    logic [7:0]       tcp_flags;
    logic [7:0]       icmp_type;
    logic [15:0]      echo_id;
    logic [15:0]      echo_seq;

    modport source (output valid, output status, output inner_protocol,
                    output inner_src_addr, output inner_dst_addr, output src_port,
                    output dst_port, output tcp_flags, output icmp_type,
                    output echo_id, output echo_seq, input ready);
    modport sink   (input valid, input status, input inner_protocol,
                    input inner_src_addr, input inner_dst_addr, input src_port,
                    input dst_port, input tcp_flags, input icmp_type,
                    input echo_id, input echo_seq, output ready);
endinterface

interface vipc_cfg_if import vipc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CfgIdxW-1:0] reg_index;
    logic [15:0]        wr_data;

    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

[hw/rtl/vipc_cfg_regs.sv]
// Configuration registers: VXLAN UDP port and VLAN tag ethertype.
// Depends on vipc_pkg.
module vipc_cfg_regs import vipc_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_valid,
    output logic               wr_ready,
    input  logic [CfgIdxW-1:0] wr_index,
    input  logic [15:0]        wr_data,
    output cfg_t               cfg
);

    cfg_t cfg_reg;

    assign wr_ready = 1'b1;
    assign cfg      = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.vxlan_udp_port <= VXLAN_PORT_RST;
            cfg_reg.vlan_tag_type  <= VLAN_TYPE_RST;
        end
        else if (wr_valid)
        begin
            unique case (wr_index)
                CFG_VXLAN_PORT: cfg_reg.vxlan_udp_port <= wr_data;
                CFG_VLAN_TYPE:  cfg_reg.vlan_tag_type  <= wr_data;
                default:
                begin
                end
            endcase
        end
    end

endmodule

[hw/rtl/vipc_parser.sv]
// Byte input register and header parser: tracks the parse phase, captures inner
// fields and forms the verdict on the last byte of a frame. Depends on vipc_pkg.
module vipc_parser import vipc_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_data,
    input  logic       in_last,
    input  cfg_t       cfg,
    input  logic       stall,
    output res_push_t  push
);

    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              in_last_reg;
    logic              adv;

    logic [PhaseW-1:0] phase_reg, phase_next;
    logic [OffW-1:0]   off_reg, off_next;
    logic [HlenW-1:0]  hlen_reg, hlen_next;
    logic [15:0]       tshift_reg, tshift_next;
    logic [StatW-1:0]  code_reg, code_next;
    logic [31:0]       src_addr_reg, src_addr_next;
    logic [31:0]       dst_addr_reg, dst_addr_next;
    logic [15:0]       port0_reg, port0_next;
    logic [15:0]       port1_reg, port1_next;
    logic [15:0]       echo_id_reg, echo_id_next;
    logic [15:0]       echo_seq_reg, echo_seq_next;
    logic [7:0]        proto_reg, proto_next;
    logic [7:0]        flags_reg, flags_next;
    logic [7:0]        icmp_reg, icmp_next;

    logic [7:0]        b;
    logic [OffW-1:0]   off;
    logic [OffW:0]     off_p1;
    logic              inner;
    logic              fixed;
    logic [StatW-1:0]  status;
    verdict_t          vd;

    assign adv      = in_valid_reg && !stall;
    assign in_ready = !in_valid_reg || adv;
    assign b        = in_byte_reg;
    assign off      = off_reg;
    assign off_p1   = {1'b0, off_reg} + {{OffW{1'b0}}, 1'b1};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_byte_reg <= in_data;
            in_last_reg <= in_last;
        end
    end

    always_comb
    begin
        phase_next    = phase_reg;
        off_next      = off_reg + {{(OffW-1){1'b0}}, 1'b1};
        hlen_next     = hlen_reg;
        tshift_next   = tshift_reg;
        code_next     = code_reg;
        src_addr_next = src_addr_reg;
        dst_addr_next = dst_addr_reg;
        port0_next    = port0_reg;
        port1_next    = port1_reg;
        echo_id_next  = echo_id_reg;
        echo_seq_next = echo_seq_reg;
        proto_next    = proto_reg;
        flags_next    = flags_reg;
        icmp_next     = icmp_reg;
        inner         = (phase_reg == PH_INNER_ETH) || (phase_reg == PH_INNER_IP);

        unique case (phase_reg)
            PH_OUTER_ETH, PH_INNER_ETH:
            begin
                tshift_next = {tshift_reg[7:0], b};
                if (off == 6'd0)
                    hlen_next = ETH_HLEN;
                if (off == 6'd13 && tshift_next == cfg.vlan_tag_type)
                    hlen_next = ETH_VLAN_HLEN;
                if (off_p1 == {1'b0, hlen_next})
                begin
                    phase_next  = inner ? PH_INNER_IP : PH_OUTER_IP;
                    off_next    = '0;
                    tshift_next = '0;
                end
            end
            PH_OUTER_IP, PH_INNER_IP:
            begin
                if (off == 6'd0 && b[3:0] < MIN_WORDS)
                begin
                    code_next  = inner ? ST_INNER_IHL : ST_OUTER_IHL;
                    phase_next = PH_DONE;
                end
                else if (off == 6'd9 && !inner && b != PROTO_UDP)
                begin
                    code_next  = ST_OUTER_NOT_UDP;
                    phase_next = PH_DONE;
                end
                else
                begin
                    if (off == 6'd0)
                        hlen_next = {b[3:0], 2'b00};
                    if (off == 6'd9 && inner)
                        proto_next = b;
                    if (inner && off >= 6'd12 && off <= 6'd15)
                        src_addr_next = {src_addr_reg[23:0], b};
                    if (inner && off >= 6'd16 && off <= 6'd19)
                        dst_addr_next = {dst_addr_reg[23:0], b};
                    if (off_p1 == {1'b0, hlen_next})
                    begin
                        off_next    = '0;
                        tshift_next = '0;
                        if (!inner)
                            phase_next = PH_OUTER_UDP;
                        else if (proto_next == PROTO_ICMP)
                            phase_next = PH_ICMP;
                        else if (proto_next == PROTO_TCP)
                            phase_next = PH_TCP;
                        else if (proto_next == PROTO_UDP)
                            phase_next = PH_UDP;
                        else
                        begin
                            code_next  = ST_OTHER;
                            phase_next = PH_DONE;
                        end
                    end
                end
            end
            PH_OUTER_UDP:
            begin
                if (off <= 6'd1)
                    port0_next = {port0_reg[7:0], b};
                else if (off <= 6'd3)
                    port1_next = {port1_reg[7:0], b};
                if (off == 6'd3 && port0_next != cfg.vxlan_udp_port
                    && port1_next != cfg.vxlan_udp_port)
                begin
                    code_next  = ST_NOT_VXLAN;
                    phase_next = PH_DONE;
                end
                else if (off == 6'd7)
                begin
                    port0_next  = '0;
                    port1_next  = '0;
                    phase_next  = PH_VXLAN;
                    off_next    = '0;
                    tshift_next = '0;
                end
            end
            PH_VXLAN:
            begin
                if (off == 6'd7)
                begin
                    phase_next  = PH_INNER_ETH;
                    off_next    = '0;
                    tshift_next = '0;
                end
            end
            PH_ICMP:
            begin
                if (off == 6'd0)
                    icmp_next = b;
                else if (off == 6'd4 || off == 6'd5)
                    echo_id_next = {echo_id_reg[7:0], b};
                else if (off == 6'd6 || off == 6'd7)
                    echo_seq_next = {echo_seq_reg[7:0], b};
                if (off == 6'd7)
                begin
                    code_next  = ST_ICMP;
                    phase_next = PH_DONE;
                end
            end
            PH_TCP:
            begin
                if (off <= 6'd1)
                    port0_next = {port0_reg[7:0], b};
                else if (off <= 6'd3)
                    port1_next = {port1_reg[7:0], b};
                else if (off == 6'd12 && b[7:4] < MIN_WORDS)
                begin
                    code_next  = ST_TCP_OFFSET;
                    phase_next = PH_DONE;
                end
                else if (off == 6'd13)
                    flags_next = b;
                if (off == 6'd19)
                begin
                    code_next  = ST_TCP;
                    phase_next = PH_DONE;
                end
            end
            PH_UDP:
            begin
                if (off <= 6'd1)
                    port0_next = {port0_reg[7:0], b};
                else if (off <= 6'd3)
                    port1_next = {port1_reg[7:0], b};
                if (off == 6'd7)
                begin
                    code_next  = ST_UDP;
                    phase_next = PH_DONE;
                end
            end
            default:
            begin
                off_next = off_reg;
            end
        endcase
    end

    always_comb
    begin
        fixed = (phase_next == PH_DONE);
        status = fixed ? code_next : ST_TRUNCATED;
        vd = '0;
        vd.status = status;
        if (status <= ST_OTHER)
        begin
            vd.inner_protocol = proto_next;
            vd.inner_src_addr = src_addr_next;
            vd.inner_dst_addr = dst_addr_next;
        end
        if (status == ST_TCP || status == ST_UDP)
        begin
            vd.src_port = port0_next;
            vd.dst_port = port1_next;
        end
        if (status == ST_TCP)
            vd.tcp_flags = flags_next;
        if (status == ST_ICMP)
        begin
            vd.icmp_type = icmp_next;
            if (icmp_next == ICMP_ECHO_REPLY || icmp_next == ICMP_ECHO)
            begin
                vd.echo_id  = echo_id_next;
                vd.echo_seq = echo_seq_next;
            end
        end
    end

    assign push.valid   = adv && in_last_reg;
    assign push.verdict = vd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_OUTER_ETH;
            off_reg      <= '0;
            hlen_reg     <= '0;
            tshift_reg   <= '0;
            code_reg     <= '0;
            src_addr_reg <= '0;
            dst_addr_reg <= '0;
            port0_reg    <= '0;
            port1_reg    <= '0;
            echo_id_reg  <= '0;
            echo_seq_reg <= '0;
            proto_reg    <= '0;
            flags_reg    <= '0;
            icmp_reg     <= '0;
        end
        else if (adv)
        begin
            if (in_last_reg)
            begin
                phase_reg    <= PH_OUTER_ETH;
                off_reg      <= '0;
                hlen_reg     <= '0;
                tshift_reg   <= '0;
                code_reg     <= '0;
                src_addr_reg <= '0;
                dst_addr_reg <= '0;
                port0_reg    <= '0;
                port1_reg    <= '0;
                echo_id_reg  <= '0;
                echo_seq_reg <= '0;
                proto_reg    <= '0;
                flags_reg    <= '0;
                icmp_reg     <= '0;
            end
            else
            begin
                phase_reg    <= phase_next;
                off_reg      <= off_next;
                hlen_reg     <= hlen_next;
                tshift_reg   <= tshift_next;
                code_reg     <= code_next;
                src_addr_reg <= src_addr_next;
                dst_addr_reg <= dst_addr_next;
                port0_reg    <= port0_next;
                port1_reg    <= port1_next;
                echo_id_reg  <= echo_id_next;
                echo_seq_reg <= echo_seq_next;
                proto_reg    <= proto_next;
                flags_reg    <= flags_next;
                icmp_reg     <= icmp_next;
            end
        end
    end

endmodule

[hw/rtl/vipc_out_buf.sv]
// Verdict output register with a skid entry behind it.
// Depends on vipc_pkg.
module vipc_out_buf import vipc_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  res_push_t push,
    output logic      stall,
    output logic      out_valid,
    input  logic      out_ready,
    output verdict_t  out_verdict
);

    logic     out_valid_reg;
    verdict_t out_reg;
    logic     skid_valid_reg;
    verdict_t skid_reg;

    assign stall       = skid_valid_reg;
    assign out_valid   = out_valid_reg;
    assign out_verdict = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= push.valid;
            end
        end
        else if (push.valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_ready)
        begin
            out_reg <= skid_valid_reg ? skid_reg : push.verdict;
        end
        else if (push.valid)
        begin
            skid_reg <= push.verdict;
        end
    end

endmodule

[hw/rtl/vxlan_inner_packet_classifier.sv]
// VXLAN inner packet classifier: one frame byte per item, one verdict per frame.
// Throughput: one byte per cycle while the skid entry is empty (it stalls the parser).
// The last byte is registered on input; its verdict is then registered at the output.
// A two-entry output (register plus skid) lets bytes keep flowing while a verdict waits.
// Reset clears parse state and restores the VXLAN port (4789) and VLAN type (0x8100).
// Depends on vipc_pkg, vipc_channels, vipc_cfg_regs, vipc_parser, vipc_out_buf.
module vxlan_inner_packet_classifier import vipc_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    vipc_frame_if.sink   frame,
    vipc_verdict_if.source verdict,
    vipc_cfg_if.sink     cfg
);

    cfg_t      cfg_regs;
    res_push_t push;
    logic      stall;
    verdict_t  vd;

    vipc_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (cfg.valid),
        .wr_ready (cfg.ready),
        .wr_index (cfg.reg_index),
        .wr_data  (cfg.wr_data),
        .cfg      (cfg_regs)
    );

    vipc_parser u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (frame.valid),
        .in_ready (frame.ready),
        .in_data  (frame.data_byte),
        .in_last  (frame.last_byte),
        .cfg      (cfg_regs),
        .stall    (stall),
        .push     (push)
    );

    vipc_out_buf u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .stall       (stall),
        .out_valid   (verdict.valid),
        .out_ready   (verdict.ready),
        .out_verdict (vd)
    );

    assign verdict.status         = vd.status;
    assign verdict.inner_protocol = vd.inner_protocol;
    assign verdict.inner_src_addr = vd.inner_src_addr;
    assign verdict.inner_dst_addr = vd.inner_dst_addr;
    assign verdict.src_port       = vd.src_port;
    assign verdict.dst_port       = vd.dst_port;
    assign verdict.tcp_flags      = vd.tcp_flags;
    assign verdict.icmp_type      = vd.icmp_type;
    assign verdict.echo_id        = vd.echo_id;
    assign verdict.echo_seq       = vd.echo_seq;

endmodule

[hw/rtl/vipc_checker.sv]
// Port-level checks for the classifier, bound to the top level.
// Depends on vipc_pkg and vxlan_inner_packet_classifier.
module vipc_checker import vipc_pkg::*; (
    input logic     clk,
    input logic     rst_n,
    input logic     frame_valid,
    input logic     frame_ready,
    input logic     frame_last,
    input logic     out_valid,
    input logic     out_ready,
    input verdict_t out_fields
);

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_fields))
        else $error("verdict dropped or changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_fields.status <= ST_TRUNCATED)
        else $error("status code out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_fields.status >= ST_OUTER_IHL |->
            out_fields.inner_protocol == '0 && out_fields.inner_src_addr == '0
            && out_fields.inner_dst_addr == '0 && out_fields.src_port == '0
            && out_fields.dst_port == '0 && out_fields.tcp_flags == '0
            && out_fields.icmp_type == '0 && out_fields.echo_id == '0
            && out_fields.echo_seq == '0)
        else $error("error verdict carries captured fields");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(frame_valid && frame_ready && frame_last, 2))
        else $error("verdict without a last byte two cycles earlier");

endmodule

bind vxlan_inner_packet_classifier vipc_checker u_vipc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .frame_valid (frame.valid),
    .frame_ready (frame.ready),
    .frame_last  (frame.last_byte),
    .out_valid   (verdict.valid),
    .out_ready   (verdict.ready),
    .out_fields  ({verdict.status, verdict.inner_protocol, verdict.inner_src_addr,
                   verdict.inner_dst_addr, verdict.src_port, verdict.dst_port,
                   verdict.tcp_flags, verdict.icmp_type, verdict.echo_id,
                   verdict.echo_seq})
);

[verif/vxlan_inner_packet_classifier_tb.sv]
// Self-checking testbench for vxlan_inner_packet_classifier: builds VXLAN frames byte by byte,
// predicts each frame's verdict and compares it field by field with the block's output.
// Depends on vipc_pkg, vipc_channels and the classifier RTL.
module vxlan_inner_packet_classifier_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vipc_pkg::*;

    localparam int CYCLE_LIMIT  = 2000000;
    localparam int DRAIN_CYCLES = 6;

    typedef enum int {FILL_RANDOM, FILL_ZEROS, FILL_ONES} fill_t;

    logic clk = 1'b0;
    logic rst_n;

    vipc_frame_if   frame_if ();
    vipc_verdict_if verdict_if ();
    vipc_cfg_if     cfg_if ();

    vxlan_inner_packet_classifier u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .frame   (frame_if),
        .verdict (verdict_if),
        .cfg     (cfg_if)
    );

    always #4 clk = ~clk;

    // register copies and per-frame parse state
    logic [15:0] cur_vxlan_port;
    logic [15:0] cur_vlan_type;
    logic [3:0]  parse_ph;
    int          sec_off;
    int          hdr_len;
    logic [15:0] type_shift;
    logic [3:0]  fixed_status;
    bit          status_fixed;
    logic [31:0] seen_src_addr;
    logic [31:0] seen_dst_addr;
    logic [15:0] seen_src_port;
    logic [15:0] seen_dst_port;
    logic [15:0] seen_echo_id;
    logic [15:0] seen_echo_seq;
    logic [7:0]  seen_proto;
    logic [7:0]  seen_flags;
    logic [7:0]  seen_icmp_type;

    verdict_t    pending_verdicts[$];
    verdict_t    want_v;
    logic [7:0]  frame_buf[$];
    fill_t       fill_mode = FILL_RANDOM;
    bit          steady;
    int          err_count;
    int          cycle_count;
    int          bytes_sent;
    int          frames_sent;
    int          verdicts_seen;
    int          settings_used;
    int          status_hits[10];

    function automatic void clear_parse();
        parse_ph       = PH_OUTER_ETH;
        sec_off        = 0;
        hdr_len        = 0;
        type_shift     = '0;
        fixed_status   = '0;
        status_fixed   = 1'b0;
        seen_src_addr  = '0;
        seen_dst_addr  = '0;
        seen_src_port  = '0;
        seen_dst_port  = '0;
        seen_echo_id   = '0;
        seen_echo_seq  = '0;
        seen_proto     = '0;
        seen_flags     = '0;
        seen_icmp_type = '0;
    endfunction

    function automatic void enter_phase(logic [3:0] ph);
        parse_ph   = ph;
        sec_off    = 0;
        type_shift = '0;
    endfunction

    function automatic void fix_status(logic [3:0] code);
        fixed_status = code;
        status_fixed = 1'b1;
        parse_ph     = PH_DONE;
    endfunction

    function automatic void parse_frame_byte(logic [7:0] b);
        int off;
        bit inner;
        off = sec_off;
        if (sec_off < 255)
            sec_off++;
        case (parse_ph)
            PH_OUTER_ETH, PH_INNER_ETH:
            begin
                inner = (parse_ph == PH_INNER_ETH);
                type_shift = {type_shift[7:0], b};
                if (off == 0)
                    hdr_len = ETH_HLEN;
                if (off == 13 && type_shift == cur_vlan_type)
                    hdr_len = ETH_VLAN_HLEN;
                if (off + 1 == hdr_len)
                    enter_phase(inner ? PH_INNER_IP : PH_OUTER_IP);
            end
            PH_OUTER_IP, PH_INNER_IP:
            begin
                inner = (parse_ph == PH_INNER_IP);
                if (off == 0)
                begin
                    hdr_len = b[3:0] * 4;
                    if (b[3:0] < MIN_WORDS)
                    begin
                        fix_status(inner ? ST_INNER_IHL : ST_OUTER_IHL);
                        return;
                    end
                end
                if (off == 9)
                begin
                    if (!inner && b != PROTO_UDP)
                    begin
                        fix_status(ST_OUTER_NOT_UDP);
                        return;
                    end
                    if (inner)
                        seen_proto = b;
                end
                if (inner && off >= 12 && off <= 15)
                    seen_src_addr = {seen_src_addr[23:0], b};
                if (inner && off >= 16 && off <= 19)
                    seen_dst_addr = {seen_dst_addr[23:0], b};
                if (off + 1 == hdr_len)
                begin
                    if (!inner)
                        enter_phase(PH_OUTER_UDP);
                    else if (seen_proto == PROTO_ICMP)
                        enter_phase(PH_ICMP);
                    else if (seen_proto == PROTO_TCP)
                        enter_phase(PH_TCP);
                    else if (seen_proto == PROTO_UDP)
                        enter_phase(PH_UDP);
                    else
                        fix_status(ST_OTHER);
                end
            end
            PH_OUTER_UDP:
            begin
                if (off <= 1)
                    seen_src_port = {seen_src_port[7:0], b};
                else if (off <= 3)
                    seen_dst_port = {seen_dst_port[7:0], b};
                if (off == 3 && seen_src_port != cur_vxlan_port &&
                    seen_dst_port != cur_vxlan_port)
                begin
                    fix_status(ST_NOT_VXLAN);
                    return;
                end
                if (off == 7)
                begin
                    seen_src_port = '0;
                    seen_dst_port = '0;
                    enter_phase(PH_VXLAN);
                end
            end
            PH_VXLAN:
            begin
                if (off == 7)
                    enter_phase(PH_INNER_ETH);
            end
            PH_ICMP:
            begin
                if (off == 0)
                    seen_icmp_type = b;
                else if (off == 4 || off == 5)
                    seen_echo_id = {seen_echo_id[7:0], b};
                else if (off == 6 || off == 7)
                    seen_echo_seq = {seen_echo_seq[7:0], b};
                if (off == 7)
                    fix_status(ST_ICMP);
            end
            PH_TCP:
            begin
                if (off <= 1)
                    seen_src_port = {seen_src_port[7:0], b};
                else if (off <= 3)
                    seen_dst_port = {seen_dst_port[7:0], b};
                else if (off == 12 && b[7:4] < MIN_WORDS)
                begin
                    fix_status(ST_TCP_OFFSET);
                    return;
                end
                else if (off == 13)
                    seen_flags = b;
                if (off == 19)
                    fix_status(ST_TCP);
            end
            PH_UDP:
            begin
                if (off <= 1)
                    seen_src_port = {seen_src_port[7:0], b};
                else if (off <= 3)
                    seen_dst_port = {seen_dst_port[7:0], b};
                if (off == 7)
                    fix_status(ST_UDP);
            end
            default: ;
        endcase
    endfunction

    function automatic void classify_byte(logic [7:0] b, bit is_last);
        verdict_t   v;
        logic [3:0] st;
        if (!status_fixed)
            parse_frame_byte(b);
        if (!is_last)
            return;
        st = status_fixed ? fixed_status : ST_TRUNCATED;
        v = '0;
        v.status = st;
        if (st <= ST_OTHER)
        begin
            v.inner_protocol = seen_proto;
            v.inner_src_addr = seen_src_addr;
            v.inner_dst_addr = seen_dst_addr;
        end
        if (st == ST_TCP || st == ST_UDP)
        begin
            v.src_port = seen_src_port;
            v.dst_port = seen_dst_port;
        end
        if (st == ST_TCP)
            v.tcp_flags = seen_flags;
        if (st == ST_ICMP)
        begin
            v.icmp_type = seen_icmp_type;
            if (seen_icmp_type == ICMP_ECHO_REPLY || seen_icmp_type == ICMP_ECHO)
            begin
                v.echo_id  = seen_echo_id;
                v.echo_seq = seen_echo_seq;
            end
        end
        pending_verdicts.push_back(v);
        clear_parse();
    endfunction

    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] fill_byte();
        case (fill_mode)
            FILL_ZEROS: return 8'h00;
            FILL_ONES:  return 8'hff;
            default:    return 8'($urandom);
        endcase
    endfunction

    function automatic void push_fill(int n);
        repeat (n) frame_buf.push_back(fill_byte());
    endfunction

    function automatic void push_word(logic [15:0] w);
        frame_buf.push_back(w[15:8]);
        frame_buf.push_back(w[7:0]);
    endfunction

    function automatic void push_eth(bit vlan);
        logic [15:0] et;
        push_fill(12);
        if (vlan)
        begin
            push_word(cur_vlan_type);
            push_fill(4);
        end
        else
        begin
            et = {fill_byte(), fill_byte()};
            if (et == cur_vlan_type)
                et = ~et;
            push_word(et);
        end
    endfunction

    function automatic void push_ip(int ihl, logic [7:0] proto);
        int         len;
        logic [7:0] t;
        len = (ihl < 5) ? 20 : ihl * 4;
        t = fill_byte();
        frame_buf.push_back({t[7:4], 4'(ihl)});
        push_fill(8);
        frame_buf.push_back(proto);
        push_fill(len - 10);
    endfunction

    // key: ICMP type, or the TCP data offset byte
    function automatic void build_frame(bit ovlan, bit ivlan, int oihl, logic [7:0] oproto,
                                        logic [15:0] usrc, logic [15:0] udst, int iihl,
                                        logic [7:0] iproto, logic [7:0] key, int payload);
        frame_buf.delete();
        push_eth(ovlan);
        push_ip(oihl, oproto);
        push_word(usrc);
        push_word(udst);
        push_fill(12);
        push_eth(ivlan);
        push_ip(iihl, iproto);
        case (iproto)
            PROTO_ICMP:
            begin
                frame_buf.push_back(key);
                push_fill(7);
            end
            PROTO_TCP:
            begin
                push_fill(12);
                frame_buf.push_back(key);
                push_fill(7);
            end
            PROTO_UDP: push_fill(8);
            default: ;
        endcase
        push_fill(payload);
    endfunction

    task automatic send_byte(logic [7:0] b, bit is_last);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            frame_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        frame_if.data_byte <= b;
        frame_if.last_byte <= is_last;
        frame_if.valid     <= 1'b1;
        @(posedge clk);
        while (!frame_if.ready)
            @(posedge clk);
        classify_byte(b, is_last);
        bytes_sent++;
    endtask

    task automatic send_frame(int cut);
        int n;
        n = frame_buf.size();
        if (cut > 0 && cut < n)
            n = cut;
        for (int i = 0; i < n; i++)
            send_byte(frame_buf[i], i == n - 1);
        frames_sent++;
    endtask

    task automatic drain();
        frame_if.valid <= 1'b0;
        wait (pending_verdicts.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // stray: also write indices beyond the register map, which must be ignored
    task automatic write_regs(logic [15:0] port, logic [15:0] vlan, bit stray);
        logic [CfgIdxW-1:0] idx[4];
        logic [15:0]        val[4];
        int                 n;
        idx[0] = CFG_VXLAN_PORT;
        val[0] = port;
        idx[1] = CFG_VLAN_TYPE;
        val[1] = vlan;
        idx[2] = CFG_VLAN_TYPE + 1;
        val[2] = 16'($urandom);
        idx[3] = '1;
        val[3] = 16'($urandom);
        n = stray ? 4 : 2;
        for (int i = 0; i < n; i++)
        begin
            cfg_if.reg_index <= idx[i];
            cfg_if.wr_data   <= val[i];
            cfg_if.valid     <= 1'b1;
            @(posedge clk);
            while (!cfg_if.ready)
                @(posedge clk);
            if (idx[i] == CFG_VXLAN_PORT)
                cur_vxlan_port = val[i];
            else if (idx[i] == CFG_VLAN_TYPE)
                cur_vlan_type = val[i];
        end
        cfg_if.valid <= 1'b0;
        settings_used++;
    endtask

    task automatic test_icmp_frames();
        fill_mode = FILL_ONES;
        build_frame(0, 0, 5, PROTO_UDP, 16'hffff, cur_vxlan_port, 5, PROTO_ICMP, ICMP_ECHO, 0);
        send_frame(0);
        fill_mode = FILL_ZEROS;
        build_frame(1, 1, 5, PROTO_UDP, cur_vxlan_port, 16'h0000, 5, PROTO_ICMP,
                    ICMP_ECHO_REPLY, 3);
        send_frame(0);
        fill_mode = FILL_RANDOM;
        build_frame(0, 1, 6, PROTO_UDP, 16'h1234, cur_vxlan_port, 7, PROTO_ICMP, 8'd3, 2);
        send_frame(0);
        build_frame(1, 0, 5, PROTO_UDP, cur_vxlan_port, cur_vxlan_port, 5, PROTO_ICMP,
                    8'hff, 0);
        send_frame(0);
    endtask

    task automatic test_tcp_frames();
        fill_mode = FILL_ONES;
        build_frame(0, 0, 5, PROTO_UDP, cur_vxlan_port, 16'hffff, 5, PROTO_TCP, 8'hff, 4);
        send_frame(0);
        fill_mode = FILL_ZEROS;
        build_frame(0, 0, 5, PROTO_UDP, 16'h0000, cur_vxlan_port, 5, PROTO_TCP, 8'h50, 0);
        send_frame(0);
        fill_mode = FILL_RANDOM;
        build_frame(1, 0, 5, PROTO_UDP, cur_vxlan_port, 16'h0035, 5, PROTO_TCP, 8'h4f, 10);
        send_frame(0);
        build_frame(0, 1, 5, PROTO_UDP, 16'h0050, cur_vxlan_port, 5, PROTO_TCP, 8'h00, 0);
        send_frame(0);
    endtask

    task automatic test_udp_and_other_frames();
        build_frame(0, 1, 5, PROTO_UDP, cur_vxlan_port, 16'h2222, 5, PROTO_UDP, 8'h00, 2);
        send_frame(0);
        build_frame(1, 1, 5, PROTO_UDP, cur_vxlan_port, 16'h3333, 15, 8'hff, 8'h00, 5);
        send_frame(0);
        build_frame(0, 0, 5, PROTO_UDP, 16'h4444, cur_vxlan_port, 5, 8'h00, 8'h00, 0);
        send_frame(0);
        build_frame(0, 0, 15, PROTO_UDP, cur_vxlan_port, 16'h5555, 5, PROTO_UDP, 8'h00, 1);
        send_frame(0);
    endtask

    task automatic test_header_errors();
        build_frame(0, 0, 4, PROTO_UDP, cur_vxlan_port, 16'h0001, 5, PROTO_ICMP, ICMP_ECHO, 0);
        send_frame(0);
        build_frame(1, 0, 0, PROTO_UDP, cur_vxlan_port, 16'h0001, 5, PROTO_ICMP, ICMP_ECHO, 20);
        send_frame(0);
        build_frame(0, 0, 5, PROTO_TCP, cur_vxlan_port, 16'h0001, 5, PROTO_UDP, 8'h00, 3);
        send_frame(0);
        build_frame(0, 1, 5, PROTO_UDP, cur_vxlan_port + 16'd1, ~cur_vxlan_port, 5, PROTO_UDP,
                    8'h00, 0);
        send_frame(0);
        build_frame(0, 0, 5, PROTO_UDP, 16'h0001, cur_vxlan_port, 3, PROTO_TCP, 8'h50, 6);
        send_frame(0);
    endtask

    task automatic test_truncation();
        build_frame(0, 0, 5, PROTO_UDP, cur_vxlan_port, 16'h0001, 5, PROTO_ICMP, ICMP_ECHO, 0);
        send_frame(1);
        build_frame(0, 0, 5, PROTO_UDP, cur_vxlan_port, 16'h0001, 5, PROTO_ICMP, ICMP_ECHO, 0);
        send_frame(frame_buf.size() - 1);
        build_frame(1, 1, 5, PROTO_UDP, cur_vxlan_port, 16'h0001, 5, PROTO_TCP, 8'h50, 0);
        send_frame(40);
    endtask

    task automatic test_register_writes();
        drain();
        write_regs(16'h0000, 16'h0000, 1'b1);
        build_frame(1, 1, 5, PROTO_UDP, 16'h0000, 16'h1111, 5, PROTO_UDP, 8'h00, 1);
        send_frame(0);
        drain();
        write_regs(16'hffff, 16'hffff, 1'b1);
        build_frame(1, 0, 5, PROTO_UDP, 16'h1111, 16'hffff, 5, PROTO_TCP, 8'h6a, 0);
        send_frame(0);
        drain();
        write_regs(VXLAN_PORT_RST, VLAN_TYPE_RST, 1'b0);
    endtask

    task automatic test_random_traffic();
        logic [15:0] port;
        logic [15:0] vlan;
        logic [15:0] usrc;
        logic [15:0] udst;
        logic [7:0]  oproto;
        logic [7:0]  iproto;
        logic [7:0]  key;
        bit          ovlan;
        bit          ivlan;
        int          oihl;
        int          iihl;
        int          payload;
        int          pick;
        int          cut;
        int          start_bytes;
        int          start_frames;
        for (int k = 0; k < 6; k++)
        begin
            case (k)
                0: begin port = VXLAN_PORT_RST; vlan = VLAN_TYPE_RST; end
                1: begin port = 16'h0000; vlan = 16'h0000; end
                2: begin port = 16'hffff; vlan = 16'hffff; end
                3: begin port = 16'($urandom); vlan = 16'h88a8; end
                4: begin port = 16'($urandom); vlan = 16'($urandom); end
                default: begin port = VXLAN_PORT_RST; vlan = VLAN_TYPE_RST; end
            endcase
            drain();
            write_regs(port, vlan, k == 3);
            start_bytes  = bytes_sent;
            start_frames = frames_sent;
            while (bytes_sent - start_bytes < 275 || frames_sent - start_frames < 8)
            begin
                steady = ($urandom_range(0, 9) < 2);
                if ($urandom_range(0, 99) < 8)
                begin
                    frame_buf.delete();
                    repeat ($urandom_range(1, 60)) frame_buf.push_back(8'($urandom));
                end
                else
                begin
                    ovlan  = $urandom_range(0, 1);
                    ivlan  = $urandom_range(0, 1);
                    oihl   = ($urandom_range(0, 9) < 8) ? 5 : $urandom_range(6, 15);
                    iihl   = ($urandom_range(0, 9) < 8) ? 5 : $urandom_range(6, 15);
                    oproto = PROTO_UDP;
                    if ($urandom_range(0, 1))
                    begin
                        usrc = cur_vxlan_port;
                        udst = 16'($urandom);
                    end
                    else
                    begin
                        usrc = 16'($urandom);
                        udst = cur_vxlan_port;
                    end
                    pick = $urandom_range(0, 99);
                    if (pick < 30)
                        iproto = PROTO_ICMP;
                    else if (pick < 60)
                        iproto = PROTO_TCP;
                    else if (pick < 85)
                        iproto = PROTO_UDP;
                    else
                        iproto = 8'($urandom);
                    pick = $urandom_range(0, 99);
                    if (iproto != PROTO_ICMP)
                        key = {4'($urandom_range(5, 15)), 4'($urandom)};
                    else if (pick < 40)
                        key = ICMP_ECHO;
                    else if (pick < 70)
                        key = ICMP_ECHO_REPLY;
                    else
                        key = 8'($urandom);
                    payload = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 4)
                                                          : $urandom_range(5, 16);
                    // inject one broken header
                    if ($urandom_range(0, 99) < 20)
                    begin
                        case ($urandom_range(0, 4))
                            0: oihl = $urandom_range(0, 4);
                            1: begin
                                oproto = 8'($urandom);
                                if (oproto == PROTO_UDP)
                                    oproto = ~oproto;
                            end
                            2: begin
                                usrc = ~cur_vxlan_port;
                                udst = cur_vxlan_port ^ (16'd1 << $urandom_range(0, 15));
                            end
                            3: iihl = $urandom_range(0, 4);
                            default: begin
                                iproto = PROTO_TCP;
                                key    = {4'($urandom_range(0, 4)), 4'($urandom)};
                            end
                        endcase
                    end
                    build_frame(ovlan, ivlan, oihl, oproto, usrc, udst, iihl, iproto, key,
                                payload);
                end
                cut = ($urandom_range(0, 99) < 20) ? $urandom_range(1, frame_buf.size()) : 0;
                send_frame(cut);
            end
        end
        steady = 1'b0;
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            err_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (rst_n && verdict_if.valid && verdict_if.ready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $error("verdict with no frame pending, status %0d", verdict_if.status);
                err_count++;
            end
            else
            begin
                want_v = pending_verdicts.pop_front();
                check_field("status", want_v.status, verdict_if.status);
                check_field("inner_protocol", want_v.inner_protocol, verdict_if.inner_protocol);
                check_field("inner_src_addr", want_v.inner_src_addr, verdict_if.inner_src_addr);
                check_field("inner_dst_addr", want_v.inner_dst_addr, verdict_if.inner_dst_addr);
                check_field("src_port", want_v.src_port, verdict_if.src_port);
                check_field("dst_port", want_v.dst_port, verdict_if.dst_port);
                check_field("tcp_flags", want_v.tcp_flags, verdict_if.tcp_flags);
                check_field("icmp_type", want_v.icmp_type, verdict_if.icmp_type);
                check_field("echo_id", want_v.echo_id, verdict_if.echo_id);
                check_field("echo_seq", want_v.echo_seq, verdict_if.echo_seq);
                if (want_v.status <= ST_TRUNCATED)
                    status_hits[want_v.status]++;
                verdicts_seen++;
            end
        end
    end

    initial
    begin : verdict_sink
        int hold;
        hold = 0;
        verdict_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                verdict_if.ready <= 1'b0;
                hold--;
            end
            else
            begin
                verdict_if.ready <= 1'b1;
                if ($urandom_range(0, 99) < 25)
                    hold = pick_gap();
            end
        end
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d verdicts outstanding", cycle_count,
                 pending_verdicts.size());
        $display("** vxlan_inner_packet_classifier: FAILED **");
        $finish;
    end

    initial
    begin
        cycle_count        = 0;
        err_count          = 0;
        rst_n              = 1'b0;
        frame_if.valid     = 1'b0;
        frame_if.data_byte = '0;
        frame_if.last_byte = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.reg_index   = '0;
        cfg_if.wr_data     = '0;
        cur_vxlan_port     = VXLAN_PORT_RST;
        cur_vlan_type      = VLAN_TYPE_RST;
        clear_parse();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_icmp_frames();
        test_tcp_frames();
        test_udp_and_other_frames();
        test_header_errors();
        test_truncation();
        test_register_writes();
        test_random_traffic();
        drain();

        $display("Sent %0d frames (%0d bytes) under %0d register settings, %0d verdicts checked.",
                 frames_sent, bytes_sent, settings_used, verdicts_seen);
        $display("By status icmp/tcp/udp/other/oihl/oproto/port/iihl/tcpoff/trunc: %0d %0d %0d %0d %0d %0d %0d %0d %0d %0d",
                 status_hits[0], status_hits[1], status_hits[2], status_hits[3],
                 status_hits[4], status_hits[5], status_hits[6], status_hits[7],
                 status_hits[8], status_hits[9]);
        if (err_count == 0)
            $display("** vxlan_inner_packet_classifier: PASSED **");
        else
            $display("** vxlan_inner_packet_classifier: FAILED **");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/vipc_pkg.sv
hw/rtl/vipc_channels.sv
hw/rtl/vipc_cfg_regs.sv
hw/rtl/vipc_parser.sv
hw/rtl/vipc_out_buf.sv
hw/rtl/vxlan_inner_packet_classifier.sv
hw/rtl/vipc_checker.sv
verif/vxlan_inner_packet_classifier_tb.sv
